// ===== rtl/wwm_pkg.sv =====
// shared types and character codes for the wildcard word matcher
package wwm_pkg;

	// beat kind carried on the input tuser
	typedef enum logic {
		OP_MASK = 1'b0,
		OP_TEXT = 1'b1
	} op_t;

	localparam logic [7:0] STAR_CHAR     = 8'd42;
	localparam logic [7:0] QUESTION_CHAR = 8'd63;
	localparam logic [7:0] SPACE_CHAR    = 8'd32;

	localparam int CHAR_W       = 8;
	localparam int MASK_IDX_W   = 5;
	localparam int MASK_LEN_W   = 6;
	localparam int WORD_START_W = 8;
	localparam int IN_DATA_W    = 16;
	localparam int OUT_DATA_W   = 16;

endpackage

// ===== rtl/wwm_step.sv =====
// next active-position vector for one text byte, with star closure
module wwm_step #(
	parameter int MASK_MAX = 32
) (
	input  logic [wwm_pkg::CHAR_W-1:0] mask_chars [MASK_MAX],
	input  logic [MASK_MAX-1:0]        pos_en,
	input  logic [MASK_MAX:0]          active,
	input  logic                       word_begin,
	input  logic [wwm_pkg::CHAR_W-1:0] text_char,
	output logic [MASK_MAX:0]          next_active
);

	localparam int N = MASK_MAX + 1;

	logic [MASK_MAX-1:0] star_p;
	logic [MASK_MAX-1:0] single_p;
	logic [N-1:0]        star_v;
	logic [N-1:0]        start_set;
	logic [N-1:0]        base;
	logic [N-1:0]        moved;
	logic [N-1:0]        star_hit;
	logic [N-1:0]        carry_sum;

	// per-position star and single-character tests
	always_comb begin
		for (int p = 0; p < MASK_MAX; p++) begin
			star_p[p]   = pos_en[p] && (mask_chars[p] == wwm_pkg::STAR_CHAR);
			single_p[p] = pos_en[p] && (mask_chars[p] != wwm_pkg::STAR_CHAR) &&
				((mask_chars[p] == wwm_pkg::QUESTION_CHAR) || (mask_chars[p] == text_char));
		end
	end

	assign star_v = {1'b0, star_p};

	// closure of position zero: leading run of stars plus the one after
	assign start_set = (star_v + N'(1)) ^ star_v;

	assign base = word_begin ? start_set : active;

	// all positions advance in parallel
	always_comb begin
		moved = '0;
		for (int p = 0; p < MASK_MAX; p++) begin
			if (base[p] && star_p[p]) begin
				moved[p] = 1'b1;
			end
			if (base[p] && single_p[p]) begin
				moved[p+1] = 1'b1;
			end
		end
	end

	// star closure as a carry chain: stars propagate, active stars generate
	assign star_hit    = star_v & moved;
	assign carry_sum   = star_v + star_hit;
	assign next_active = moved | (carry_sum ^ star_v ^ star_hit);

endmodule

// ===== rtl/wildcard_word_matcher.sv =====
// top level of the wildcard word matcher: input stage, match state, result register
//
// The block takes one beat per clock on the input stream, mask-load and text beats
// alike, while the output side keeps up, and gives one result beat for every non-empty
// space-separated word, on the byte that closes it (a space, or the beat marked last).
// An accepted beat is registered in the input stage and evaluated there; its result is
// registered in the result register and shows on the output from then on. The per-byte
// work is set by the active-position vector update: every mask position steps in
// parallel and star closure is one carry-chain add of MASK_MAX+1 bits. A '*' matches
// any run, '?' any single byte; a mask length above MASK_MAX acts as MASK_MAX, and an
// empty mask matches nothing. Text positions saturate at TEXT_POSITION_MAX-1 and
// restart at zero after the last beat of a text.
module wildcard_word_matcher #(
	parameter int MASK_MAX          = 32,
	parameter int TEXT_POSITION_MAX = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration: mask_length
	input  logic                                cfg_we,
	input  logic [wwm_pkg::MASK_LEN_W-1:0]      cfg_wdata,
	// input stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// tdata: mask_index [4:0], char_value [12:5], zero [15:13]
	input  logic [wwm_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// tuser: op
	input  logic                                s_axis_tuser,
	// tlast: end_of_text
	input  logic                                s_axis_tlast,
	// result stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// tdata: word_start [7:0], matched [8], any_match [9], zero [15:10]
	output logic [wwm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// tlast: text_done
	output logic                                m_axis_tlast
);

	localparam int N  = MASK_MAX + 1;
	localparam int LW = $clog2(MASK_MAX + 1);
	localparam int PW = $clog2(TEXT_POSITION_MAX);
	localparam logic [PW-1:0] POS_LAST = PW'(TEXT_POSITION_MAX - 1);

	// input stage
	logic                             valid_s1;
	wwm_pkg::op_t                     op_s1;
	logic [wwm_pkg::MASK_IDX_W-1:0]   idx_s1;
	logic [wwm_pkg::CHAR_W-1:0]       char_s1;
	logic                             eot_s1;

	// match state
	logic [wwm_pkg::CHAR_W-1:0]       mask_q [MASK_MAX];
	logic [wwm_pkg::MASK_LEN_W-1:0]   mask_length_q;
	logic [N-1:0]                     active_q;
	logic [PW-1:0]                    pos_q;
	logic [PW-1:0]                    word_start_q;
	logic                             in_word_q;
	logic                             any_q;

	// result register
	logic                             out_valid_q;
	logic [wwm_pkg::WORD_START_W-1:0] out_start_q;
	logic                             out_matched_q;
	logic                             out_any_q;
	logic                             out_done_q;

	logic                             proc;
	logic                             text_beat;
	logic                             is_space;
	logic                             word_begin;
	logic                             word_end;
	logic                             hit;
	logic [MASK_MAX-1:0]              pos_en;
	logic [LW-1:0]                    used_len;
	logic [N-1:0]                     next_active;
	logic [N-1:0]                     eval_active;
	logic [wwm_pkg::WORD_START_W-1:0] start_byte;

	// beat in the input stage moves on once the result register can take a beat
	assign proc          = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1   <= wwm_pkg::op_t'(s_axis_tuser);
			idx_s1  <= s_axis_tdata[wwm_pkg::MASK_IDX_W-1:0];
			char_s1 <= s_axis_tdata[wwm_pkg::MASK_IDX_W +: wwm_pkg::CHAR_W];
			eot_s1  <= s_axis_tlast;
		end
	end

	// mask length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_length_q <= '0;
		end else if (cfg_we) begin
			mask_length_q <= cfg_wdata;
		end
	end

	// mask characters, writes beyond the store are dropped
	always_ff @(posedge clk) begin
		if (proc && (op_s1 == wwm_pkg::OP_MASK)) begin
			for (int p = 0; p < MASK_MAX; p++) begin
				if (32'(idx_s1) == p) begin
					mask_q[p] <= char_s1;
				end
			end
		end
	end

	// positions in use and the accepting position
	always_comb begin
		for (int p = 0; p < MASK_MAX; p++) begin
			pos_en[p] = 32'(mask_length_q) > p;
		end
	end

	assign used_len = (32'(mask_length_q) > MASK_MAX) ? LW'(MASK_MAX) : LW'(mask_length_q);

	wwm_step #(
		.MASK_MAX (MASK_MAX)
	) u_step (
		.mask_chars  (mask_q),
		.pos_en      (pos_en),
		.active      (active_q),
		.word_begin  (word_begin),
		.text_char   (char_s1),
		.next_active (next_active)
	);

	// word boundary decode
	assign text_beat   = proc && (op_s1 == wwm_pkg::OP_TEXT);
	assign is_space    = (char_s1 == wwm_pkg::SPACE_CHAR);
	assign word_begin  = !is_space && !in_word_q;
	assign word_end    = (in_word_q || !is_space) && (is_space || eot_s1);
	assign eval_active = is_space ? active_q : next_active;
	assign hit         = eval_active[used_len];

	// match state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= N'(1);
			pos_q        <= '0;
			word_start_q <= '0;
			in_word_q    <= 1'b0;
			any_q        <= 1'b0;
		end else if (text_beat) begin
			if (eot_s1) begin
				active_q     <= N'(1);
				pos_q        <= '0;
				word_start_q <= '0;
				in_word_q    <= 1'b0;
				any_q        <= 1'b0;
			end else begin
				if (!is_space) begin
					active_q <= next_active;
				end
				if (word_begin) begin
					word_start_q <= pos_q;
				end
				if (pos_q != POS_LAST) begin
					pos_q <= pos_q + PW'(1);
				end
				in_word_q <= !word_end && (in_word_q || !is_space);
				any_q     <= any_q || (word_end && hit);
			end
		end
	end

	// start position of the word closing now, in result width
	if (PW >= wwm_pkg::WORD_START_W) begin : g_start_wide
		assign start_byte = word_begin ? pos_q[wwm_pkg::WORD_START_W-1:0]
		                               : word_start_q[wwm_pkg::WORD_START_W-1:0];
	end else begin : g_start_narrow
		assign start_byte = word_begin ? {{(wwm_pkg::WORD_START_W-PW){1'b0}}, pos_q}
		                               : {{(wwm_pkg::WORD_START_W-PW){1'b0}}, word_start_q};
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc) begin
			out_valid_q <= text_beat && word_end;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_beat && word_end) begin
			out_start_q   <= start_byte;
			out_matched_q <= hit;
			out_any_q     <= any_q || hit;
			out_done_q    <= eot_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_any_q, out_matched_q, out_start_q};
	assign m_axis_tlast  = out_done_q;

	// a matched word always shows in the running any-match flag
	a_match_implies_any : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_matched_q || out_any_q))
		else $error("matched result without any_match");

	// the last beat of a text clears position and word state
	a_text_end_clears : assert property (@(posedge clk) disable iff (!arst_n)
		(text_beat && eot_s1) |=> ((pos_q == '0) && !in_word_q && !any_q))
		else $error("text state not cleared after last beat");

	// a beat held in the input stage is not dropped
	a_stage_holds : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !proc) |=> valid_s1)
		else $error("input stage beat lost");

endmodule

// ===== test/wildcard_word_matcher_tb.sv =====
// self-checking testbench for the wildcard word matcher: glob predictor, random texts and masks
`timescale 1ns / 100ps

module wildcard_word_matcher_tb;

	localparam int WORD_BEATS    = 950;
	localparam int STALL_LIMIT   = 2000;
	localparam int TEXT_POS_LAST = 255;
	localparam int MASK_SLOTS    = 32;

	// one input beat as the predictor sees it
	typedef struct {
		wwm_pkg::op_t op;
		bit [4:0]     idx;
		bit [7:0]     ch;
		bit           eot;
	} beat_t;

	// one finished word
	typedef struct {
		bit [7:0]  word_start;
		bit        matched;
		bit        text_done;
		bit        any_match;
	} word_t;

	// glob predictor over a bit-vector of live mask positions, plus the expected word queue
	class glob_word_checker;
		bit [7:0]    mask_chars [MASK_SLOTS];
		bit [5:0]    mask_len;
		bit [32:0]   live;
		int unsigned pos;
		bit [7:0]    start_pos;
		bit          in_word;
		bit          any_hit;
		word_t       pending_words [$];
		int          errors;
		int          text_beats;
		int          mask_beats;
		int          words;
		int          hits;
		int          texts;
		int          lengths_used;

		function new();
			live = 33'd1;
		endfunction

		function int used_len();
			return (mask_len > MASK_SLOTS) ? MASK_SLOTS : int'(mask_len);
		endfunction

		function void set_length(bit [5:0] len);
			mask_len = len;
			lengths_used++;
		endfunction

		function int pending();
			return pending_words.size();
		endfunction

		// a star can also match the empty run, so its successor is live too
		function bit [32:0] close_stars(bit [32:0] v);
			int p;
			for (p = 0; p < used_len(); p++)
				if (v[p] && mask_chars[p] == wwm_pkg::STAR_CHAR)
					v[p + 1] = 1'b1;
			return v;
		endfunction

		function bit [32:0] step_live(bit [32:0] v, bit [7:0] c);
			bit [32:0] nv;
			int p;
			nv = '0;
			for (p = 0; p < used_len(); p++) begin
				if (v[p]) begin
					if (mask_chars[p] == wwm_pkg::STAR_CHAR)
						nv[p] = 1'b1;
					else if (mask_chars[p] == wwm_pkg::QUESTION_CHAR || mask_chars[p] == c)
						nv[p + 1] = 1'b1;
				end
			end
			return close_stars(nv);
		endfunction

		function void take_beat(beat_t b);
			word_t w;
			if (b.op == wwm_pkg::OP_MASK) begin
				mask_chars[b.idx] = b.ch;
				mask_beats++;
				return;
			end
			text_beats++;
			// word characters advance the live set
			if (b.ch != wwm_pkg::SPACE_CHAR) begin
				if (!in_word) begin
					in_word = 1'b1;
					start_pos = pos[7:0];
					live = close_stars(33'd1);
				end
				live = step_live(live, b.ch);
			end
			// a space or the last beat closes an open word
			if (in_word && (b.ch == wwm_pkg::SPACE_CHAR || b.eot)) begin
				w.matched = live[used_len()];
				if (w.matched)
					any_hit = 1'b1;
				w.word_start = start_pos;
				w.text_done = b.eot;
				w.any_match = any_hit;
				pending_words.push_back(w);
				in_word = 1'b0;
			end
			if (pos < TEXT_POS_LAST)
				pos++;
			// end of text clears the per-text state
			if (b.eot) begin
				pos = 0;
				start_pos = '0;
				in_word = 1'b0;
				any_hit = 1'b0;
				live = 33'd1;
			end
		endfunction

		function void check_word(logic [wwm_pkg::OUT_DATA_W-1:0] d, logic last);
			word_t w;
			if (pending_words.size() == 0) begin
				$error("unexpected result beat: tdata %h tlast %b", d, last);
				errors++;
				return;
			end
			w = pending_words.pop_front();
			words++;
			if (w.matched)
				hits++;
			if (w.text_done)
				texts++;
			if (d[7:0] !== w.word_start) begin
				$error("word_start mismatch: expected %0d, got %0d", w.word_start, d[7:0]);
				errors++;
			end
			if (d[8] !== w.matched) begin
				$error("matched mismatch: expected %0d, got %0d", w.matched, d[8]);
				errors++;
			end
			if (d[9] !== w.any_match) begin
				$error("any_match mismatch: expected %0d, got %0d", w.any_match, d[9]);
				errors++;
			end
			if (last !== w.text_done) begin
				$error("text_done mismatch: expected %0d, got %0d", w.text_done, last);
				errors++;
			end
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [wwm_pkg::MASK_LEN_W-1:0] cfg_wdata;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [wwm_pkg::IN_DATA_W-1:0]  s_axis_tdata;
	logic                           s_axis_tuser;
	logic                           s_axis_tlast;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	logic [wwm_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic                           m_axis_tlast;

	glob_word_checker sb;
	bit               calm;
	logic [7:0]       mask_pat [MASK_SLOTS];
	int               gen_len;
	logic [7:0]       text_q [$];

	wildcard_word_matcher dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// drive one beat, with a random gap in front, and hand it to the predictor once taken
	task automatic push_beat(wwm_pkg::op_t op, logic [4:0] idx, logic [7:0] ch, logic eot);
		beat_t b;
		b.op = op;
		b.idx = idx;
		b.ch = ch;
		b.eot = eot;
		if (!calm && $urandom_range(0, 99) < 14) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, ch, idx};
		s_axis_tuser <= op;
		s_axis_tlast <= eot;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.take_beat(b);
	endtask

	task automatic put_mask(logic [4:0] idx, logic [7:0] ch, logic eot);
		mask_pat[idx] = ch;
		push_beat(wwm_pkg::OP_MASK, idx, ch, eot);
	endtask

	task automatic text_byte(logic [7:0] ch, logic eot);
		push_beat(wwm_pkg::OP_TEXT, 5'($urandom_range(0, 31)), ch, eot);
	endtask

	// hold the sender until every expected word is out and the pipe is empty
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_length(int len);
		cfg_we <= 1'b1;
		cfg_wdata <= wwm_pkg::MASK_LEN_W'(len);
		@(posedge clk);
		sb.set_length(wwm_pkg::MASK_LEN_W'(len));
		cfg_we <= 1'b0;
		gen_len = len;
	endtask

	function automatic logic [7:0] mask_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20)
			return wwm_pkg::STAR_CHAR;
		if (r < 35)
			return wwm_pkg::QUESTION_CHAR;
		if (r < 92)
			return 8'd97 + 8'($urandom_range(0, 2));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] word_char();
		logic [7:0] c;
		if ($urandom_range(0, 99) < 60)
			return 8'd97 + 8'($urandom_range(0, 2));
		do
			c = 8'($urandom_range(0, 255));
		while (c == wwm_pkg::SPACE_CHAR);
		return c;
	endfunction

	// every position the mask length reads gets written
	task automatic load_mask(int len);
		int n;
		int i;
		n = (len > MASK_SLOTS) ? MASK_SLOTS : len;
		for (i = 0; i < n; i++)
			put_mask(5'(i), mask_char(), $urandom_range(0, 9) == 0);
	endtask

	// a word built along the mask, sometimes disturbed, or plain random bytes
	task automatic add_word(bit follow_mask);
		int n0;
		int p;
		int used;
		n0 = text_q.size();
		used = (gen_len > MASK_SLOTS) ? MASK_SLOTS : gen_len;
		if (follow_mask) begin
			for (p = 0; p < used; p++) begin
				case (mask_pat[p])
					wwm_pkg::STAR_CHAR:
						repeat ($urandom_range(0, 3)) text_q.push_back(word_char());
					wwm_pkg::QUESTION_CHAR: text_q.push_back(word_char());
					wwm_pkg::SPACE_CHAR:    text_q.push_back(word_char());
					default:                text_q.push_back(mask_pat[p]);
				endcase
			end
		end else begin
			repeat ($urandom_range(1, 6)) text_q.push_back(word_char());
		end
		if (text_q.size() == n0)
			text_q.push_back(word_char());
		if (follow_mask && $urandom_range(0, 3) == 0)
			text_q[$urandom_range(n0, text_q.size() - 1)] = word_char();
	endtask

	// one text: optional leading space, words split by runs of spaces, varied endings
	task automatic send_text(int nwords, int follow_pct);
		int w;
		int i;
		text_q.delete();
		if ($urandom_range(0, 4) == 0)
			text_q.push_back(wwm_pkg::SPACE_CHAR);
		for (w = 0; w < nwords; w++) begin
			add_word($urandom_range(0, 99) < follow_pct);
			if (w != nwords - 1)
				repeat ($urandom_range(1, 2)) text_q.push_back(wwm_pkg::SPACE_CHAR);
		end
		case ($urandom_range(0, 3))
			0:       text_q.push_back(wwm_pkg::SPACE_CHAR);
			1:       repeat (2) text_q.push_back(wwm_pkg::SPACE_CHAR);
			default: ;
		endcase
		for (i = 0; i < text_q.size(); i++) begin
			if ($urandom_range(0, 99) < 3)
				put_mask(5'($urandom_range(0, 31)), mask_char(), 1'b0);
			text_byte(text_q[i], i == text_q.size() - 1);
		end
	endtask

	// result side: random backpressure, check every beat taken
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_word(m_axis_tdata, m_axis_tlast);
			m_axis_tready <= calm || ($urandom_range(0, 99) >= 14);
		end
	end

	// watchdog on cycles with no beat on either side
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("wildcard_word_matcher test failed");
		$finish;
	end

	// stimulus
	initial begin : stimulus
		int phase;
		int len;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		calm = 1'b0;
		gen_len = 0;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty mask after reset: a one-byte text matches nothing
		text_byte("x", 1'b1);
		settle();
		write_length(3);
		// mask a*? with tlast on a mask beat, which is ignored
		put_mask(5'd0, "a", 1'b0);
		put_mask(5'd1, wwm_pkg::STAR_CHAR, 1'b0);
		put_mask(5'd2, wwm_pkg::QUESTION_CHAR, 1'b1);
		// leading space, a match, a run of spaces, a miss, bytes zero and all-ones
		text_byte(wwm_pkg::SPACE_CHAR, 1'b0);
		text_byte("a", 1'b0);
		text_byte("b", 1'b0);
		text_byte(wwm_pkg::SPACE_CHAR, 1'b0);
		text_byte(wwm_pkg::SPACE_CHAR, 1'b0);
		text_byte("a", 1'b0);
		text_byte(wwm_pkg::SPACE_CHAR, 1'b0);
		text_byte("a", 1'b0);
		text_byte(8'h00, 1'b0);
		text_byte(8'hff, 1'b0);
		text_byte(wwm_pkg::SPACE_CHAR, 1'b0);
		// mask rewritten in the middle of a word, text closed on its last byte
		text_byte("a", 1'b0);
		put_mask(5'd2, "c", 1'b0);
		text_byte("x", 1'b0);
		text_byte("c", 1'b1);
		// highest mask slot, then a text that ends with no word open
		put_mask(5'd31, 8'hff, 1'b0);
		text_byte(wwm_pkg::SPACE_CHAR, 1'b0);
		text_byte(wwm_pkg::SPACE_CHAR, 1'b1);

		// random phases, each with its own mask length; the settle is a full drain every time
		phase = 0;
		while (sb.text_beats + sb.mask_beats < WORD_BEATS) begin
			settle();
			case (phase)
				0:       len = 32;
				1:       len = 63;
				2:       len = 1;
				3:       len = 0;
				default: len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 40)
				                                           : $urandom_range(1, 8);
			endcase
			calm = (phase == 4 || phase == 5);
			write_length(len);
			load_mask(len);
			if (phase == 2)
				send_text(120, 80);
			else if (len > 16)
				repeat (2) send_text($urandom_range(1, 2), 70);
			else
				repeat ($urandom_range(1, 3)) send_text($urandom_range(1, 5), 70);
			phase++;
		end
		calm = 1'b0;
		settle();
		repeat (10) @(posedge clk);

		$display("covered %0d text beats and %0d mask beats over %0d mask length settings",
		         sb.text_beats, sb.mask_beats, sb.lengths_used);
		$display("%0d words checked, %0d matched, %0d texts closed by a word",
		         sb.words, sb.hits, sb.texts);
		if (sb.errors == 0)
			$display("wildcard_word_matcher test passed");
		else
			$display("wildcard_word_matcher test failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/wwm_pkg.sv
rtl/wwm_step.sv
rtl/wildcard_word_matcher.sv
test/wildcard_word_matcher_tb.sv
